### hw/rtl/tfpm_pkg.sv
`timescale 1ns / 1ps

package tfpm_pkg;

  localparam int DIGIT_W   = 28;
  localparam int PROD_W    = 2 * DIGIT_W;
  // Column sums hold up to three products plus a carry in.
  localparam int SUM_W     = PROD_W + 3;
  localparam int BYTE_W    = 8;
  localparam int BYTE_POS  = 16;
  localparam int OUT_SHIFT = 20;
  localparam int ROUND_POS = 19;
  localparam int PIPE_LAT  = 6;

  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << ROUND_POS;

  typedef enum logic [1:0] {
    OP_MUL    = 2'd0,
    OP_SQUARE = 2'd1,
    OP_HIGH   = 2'd2
  } op_e;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [2:0]       num_t;
  typedef logic [PROD_W-1:0]  prod_t;
  // Indexed [digit of a][digit of b].
  typedef prod_t [2:0][2:0]   prod_grid_t;

endpackage

### hw/rtl/tfpm_operand.sv
`timescale 1ns / 1ps

module tfpm_operand import tfpm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          operation_i,
  input  num_t                a_i,
  input  num_t                b_i,
  input  logic [BYTE_W-1:0]   b_byte_i,
  output logic                valid_o,
  output num_t                a_o,
  output num_t                b_o
);

  logic valid_q;
  num_t a_q;
  num_t b_q;
  num_t b_d;

  always_comb begin
    case (op_e'(operation_i))
      OP_SQUARE: b_d = a_i;
      OP_HIGH: begin
        b_d    = '0;
        b_d[2] = digit_t'(b_byte_i) << BYTE_POS;
      end
      // The spare code multiplies like OP_MUL.
      default: b_d = b_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_q <= a_i;
      b_q <= b_d;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;

endmodule

### hw/rtl/tfpm_mul_array.sv
`timescale 1ns / 1ps

module tfpm_mul_array import tfpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  num_t       a_i,
  input  num_t       b_i,
  output logic       valid_o,
  output prod_grid_t prod_o
);

  logic       valid_q;
  prod_grid_t prod_q;
  prod_grid_t prod_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = PROD_W'(a_i[i]) * PROD_W'(b_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

### hw/rtl/tfpm_carry.sv
`timescale 1ns / 1ps

module tfpm_carry import tfpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  prod_grid_t prod_i,
  output logic       valid_o,
  output num_t       r_o
);

  localparam int KEEP_W = DIGIT_W - OUT_SHIFT;

  logic [2:0] valid_q;

  // Column sums.
  logic [SUM_W-1:0] t1_q, c2_q, c3a_q;
  prod_t            c4a_q;
  // Carry into the third column resolved.
  logic [SUM_W-1:0] t2_q, c3b_q;
  prod_t            c4b_q;
  // Carry into the fourth column resolved.
  logic [SUM_W-1:0]  t3_q;
  logic [KEEP_W-1:0] t2f_q;
  prod_t             c4c_q;

  logic             out_valid_q;
  num_t             r_q;
  logic [SUM_W-1:0] t4;
  num_t             r_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= {valid_q[1:0], valid_i};
      out_valid_q <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      t1_q  <= SUM_W'(prod_i[0][0] >> DIGIT_W) + SUM_W'(prod_i[1][0])
             + SUM_W'(prod_i[0][1]);
      c2_q  <= SUM_W'(prod_i[2][0]) + SUM_W'(prod_i[1][1])
             + SUM_W'(prod_i[0][2]) + ROUND_ADD;
      c3a_q <= SUM_W'(prod_i[2][1]) + SUM_W'(prod_i[1][2]);
      c4a_q <= prod_i[2][2];
    end
    if (valid_q[0]) begin
      t2_q  <= (t1_q >> DIGIT_W) + c2_q;
      c3b_q <= c3a_q;
      c4b_q <= c4a_q;
    end
    if (valid_q[1]) begin
      t3_q  <= (t2_q >> DIGIT_W) + c3b_q;
      t2f_q <= t2_q[DIGIT_W-1:OUT_SHIFT];
      c4c_q <= c4b_q;
    end
    if (valid_q[2]) begin
      r_q <= r_d;
    end
  end

  // The final shift drops the low OUT_SHIFT bits of the third column and
  // anything above the top digit.
  always_comb begin
    t4     = (t3_q >> DIGIT_W) + SUM_W'(c4c_q);
    r_d[0] = {t3_q[OUT_SHIFT-1:0], t2f_q};
    r_d[1] = {t4[OUT_SHIFT-1:0], t3_q[DIGIT_W-1:OUT_SHIFT]};
    r_d[2] = t4[OUT_SHIFT+DIGIT_W-1:OUT_SHIFT];
  end

  assign valid_o = out_valid_q;
  assign r_o     = r_q;

endmodule

### hw/rtl/truncated_fixed_point_multiply.sv
`timescale 1ns / 1ps
// Truncated fixed-point multiplier for positive values with 76 fractional
// bits, held as three 28-bit digits per operand and per result.
// Request channel: drive operation_i and the operand digits and raise
// start_i; the request is taken at any rising edge where start_i is high
// and busy_o is low. busy_o is always low, so one request can be taken in
// every cycle.
// Result channel: valid_o is high for exactly one cycle with r_lo_o,
// r_mid_o and r_hi_o. The receiver cannot stall, so each result must be
// taken in the cycle it appears.
// From the accepting edge a request passes the operand register, the
// register for the nine 28x28 partial products, then column sums and carry
// resolution in the column-sum, t2, t3 and result registers, where each
// carry between columns gets its own adder stage.
// Throughput is one request per cycle; results come out in request order.
// Reset clears all pipeline valid bits, so no result appears after reset
// until a new request is taken.
module truncated_fixed_point_multiply import tfpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic [DIGIT_W-1:0] a_lo_i,
  input  logic [DIGIT_W-1:0] a_mid_i,
  input  logic [DIGIT_W-1:0] a_hi_i,
  input  logic [DIGIT_W-1:0] b_lo_i,
  input  logic [DIGIT_W-1:0] b_mid_i,
  input  logic [DIGIT_W-1:0] b_hi_i,
  input  logic [BYTE_W-1:0]  b_byte_i,
  output logic               valid_o,
  output logic [DIGIT_W-1:0] r_lo_o,
  output logic [DIGIT_W-1:0] r_mid_o,
  output logic [DIGIT_W-1:0] r_hi_o
);

  logic       accept;
  logic       op_valid;
  num_t       a_in, b_in, a_reg, b_reg;
  logic       mul_valid;
  prod_grid_t prod;
  num_t       r;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign a_in   = {a_hi_i, a_mid_i, a_lo_i};
  assign b_in   = {b_hi_i, b_mid_i, b_lo_i};

  tfpm_operand u_operand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .a_i         (a_in),
    .b_i         (b_in),
    .b_byte_i    (b_byte_i),
    .valid_o     (op_valid),
    .a_o         (a_reg),
    .b_o         (b_reg)
  );

  tfpm_mul_array u_mul_array (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (op_valid),
    .a_i     (a_reg),
    .b_i     (b_reg),
    .valid_o (mul_valid),
    .prod_o  (prod)
  );

  tfpm_carry u_carry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .prod_i  (prod),
    .valid_o (valid_o),
    .r_o     (r)
  );

  assign r_lo_o  = r[0];
  assign r_mid_o = r[1];
  assign r_hi_o  = r[2];

  // Every request yields a result after the pipeline latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PIPE_LAT valid_o)
    else $error("request did not produce a result on time");

  // No result appears without a request that latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, PIPE_LAT))
    else $error("result without a matching request");

  // A zero high byte gives a zero product; the rounding bit alone is shifted out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (operation_i == OP_HIGH) && (b_byte_i == '0)
    |-> ##PIPE_LAT (r_lo_o == '0) && (r_mid_o == '0) && (r_hi_o == '0))
    else $error("nonzero product for a zero high byte");

endmodule

### bench/truncated_fixed_point_multiply_tb.sv
`timescale 1ns / 1ps

module truncated_fixed_point_multiply_tb;
  import tfpm_pkg::*;

  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam int          WATCHDOG_LIMIT = 200;
  localparam int          PHASE_ITEMS    = 195;
  localparam digit_t      DIGIT_MAX      = '1;
  localparam logic [63:0] DIGIT_MASK     = (64'd1 << DIGIT_W) - 64'd1;

  typedef struct packed {
    logic [1:0]        op;
    num_t              a;
    num_t              b;
    logic [BYTE_W-1:0] hb;
  } mul_request_t;

  class product_scoreboard;
    num_t        expected_products[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function num_t truncated_product(mul_request_t req);
      num_t        b;
      num_t        r;
      logic [63:0] x [3];
      logic [63:0] y [3];
      logic [63:0] t1, t2, t3, t4;
      case (req.op)
        OP_SQUARE: b = req.a;
        OP_HIGH: begin
          b    = '0;
          b[2] = digit_t'(req.hb) << BYTE_POS;
        end
        default: b = req.b;
      endcase
      for (int i = 0; i < 3; i++) begin
        x[i] = 64'(req.a[i]);
        y[i] = 64'(b[i]);
      end
      // Column sums are taken in 64 bits, wide enough that they never wrap.
      t1 = ((x[0] * y[0]) >> DIGIT_W) + x[1] * y[0] + x[0] * y[1];
      t2 = (t1 >> DIGIT_W) + x[2] * y[0] + x[1] * y[1] + x[0] * y[2]
           + (64'd1 << ROUND_POS);
      t3 = (t2 >> DIGIT_W) + x[2] * y[1] + x[1] * y[2];
      t4 = (t3 >> DIGIT_W) + x[2] * y[2];
      r[0] = digit_t'(((t2 & DIGIT_MASK) >> OUT_SHIFT)
                      | ((t3 & DIGIT_MASK) << (DIGIT_W - OUT_SHIFT)));
      r[1] = digit_t'(((t3 & DIGIT_MASK) >> OUT_SHIFT) | (t4 << (DIGIT_W - OUT_SHIFT)));
      r[2] = digit_t'(t4 >> OUT_SHIFT);
      return r;
    endfunction

    function void note_request(mul_request_t req);
      expected_products.push_back(truncated_product(req));
    endfunction

    function int pending();
      return expected_products.size();
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
    endtask

    task check_result(num_t got);
      num_t want;
      if (expected_products.size() == 0) begin
        report_mismatch($sformatf("unexpected result %07h %07h %07h",
                                  got[2], got[1], got[0]));
      end else begin
        want = expected_products.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want[i]) begin
            report_mismatch($sformatf("result digit %0d is %07h, expected %07h",
                                      i, got[i], want[i]));
          end
        end
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        operation_i;
  digit_t            a_lo_i, a_mid_i, a_hi_i;
  digit_t            b_lo_i, b_mid_i, b_hi_i;
  logic [BYTE_W-1:0] b_byte_i;
  logic              valid_o;
  digit_t            r_lo_o, r_mid_o, r_hi_o;

  product_scoreboard sb = new();
  int unsigned       idle_cycles = 0;

  truncated_fixed_point_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .a_lo_i      (a_lo_i),
    .a_mid_i     (a_mid_i),
    .a_hi_i      (a_hi_i),
    .b_lo_i      (b_lo_i),
    .b_mid_i     (b_mid_i),
    .b_hi_i      (b_hi_i),
    .b_byte_i    (b_byte_i),
    .valid_o     (valid_o),
    .r_lo_o      (r_lo_o),
    .r_mid_o     (r_mid_o),
    .r_hi_o      (r_hi_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Inputs change only by nonblocking writes at the edge, so the values seen
  // here are the ones the block takes at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      sb.note_request(mul_request_t'({operation_i, a_hi_i, a_mid_i, a_lo_i,
                                      b_hi_i, b_mid_i, b_lo_i, b_byte_i}));
    end
    if (rst_ni && valid_o) begin
      sb.check_result({r_hi_o, r_mid_o, r_lo_o});
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic mul_request_t make_request(logic [1:0] op, num_t a, num_t b,
                                                logic [BYTE_W-1:0] hb);
    mul_request_t req;
    req.op = op;
    req.a  = a;
    req.b  = b;
    req.hb = hb;
    return req;
  endfunction

  // Digits lean toward zero, one, all ones and single bits, where carries
  // and truncation are most likely to go wrong.
  function automatic digit_t rand_digit();
    case ($urandom_range(9))
      0: return '0;
      1: return DIGIT_MAX;
      2: return digit_t'(1);
      3: return digit_t'(1) << $urandom_range(DIGIT_W - 1);
      4: return ~(digit_t'(1) << $urandom_range(DIGIT_W - 1));
      default: return digit_t'($urandom());
    endcase
  endfunction

  function automatic num_t rand_num();
    return {rand_digit(), rand_digit(), rand_digit()};
  endfunction

  function automatic mul_request_t random_request();
    int unsigned       pick;
    logic [1:0]        op;
    logic [BYTE_W-1:0] hb;
    pick = $urandom_range(99);
    if (pick < 35) begin
      op = OP_MUL;
    end else if (pick < 60) begin
      op = OP_SQUARE;
    end else if (pick < 90) begin
      op = OP_HIGH;
    end else begin
      op = OP_SPARE;
    end
    case ($urandom_range(3))
      0: hb = '1;
      1: hb = '0;
      default: hb = BYTE_W'($urandom());
    endcase
    return make_request(op, rand_num(), rand_num(), hb);
  endfunction

  task automatic send_request(mul_request_t req);
    start_i     <= 1'b1;
    operation_i <= req.op;
    {a_hi_i, a_mid_i, a_lo_i} <= req.a;
    {b_hi_i, b_mid_i, b_lo_i} <= req.b;
    b_byte_i    <= req.hb;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Each cycle before a request is idle with the given chance, so that share
  // of all cycles carries no request; the idle inputs carry junk.
  task automatic maybe_idle(int unsigned percent);
    mul_request_t junk;
    while ($urandom_range(99) < percent) begin
      junk = random_request();
      start_i     <= 1'b0;
      operation_i <= junk.op;
      {a_hi_i, a_mid_i, a_lo_i} <= junk.a;
      {b_hi_i, b_mid_i, b_lo_i} <= junk.b;
      b_byte_i    <= junk.hb;
      @(posedge clk_i);
    end
  endtask

  task automatic run_directed();
    num_t zero;
    num_t ones;
    num_t unit;
    zero = '0;
    ones = {DIGIT_MAX, DIGIT_MAX, DIGIT_MAX};
    // 1.0 in this format is 2^76, so digit 2 holds bit 20.
    unit = {digit_t'(1) << OUT_SHIFT, digit_t'(0), digit_t'(0)};
    send_request(make_request(OP_MUL, zero, zero, '0));
    send_request(make_request(OP_MUL, ones, ones, '1));
    send_request(make_request(OP_SQUARE, ones, zero, '1));
    send_request(make_request(OP_HIGH, ones, ones, '1));
    send_request(make_request(OP_HIGH, ones, ones, '0));
    send_request(make_request(OP_HIGH, {28'd0, 28'd0, 28'd1}, ones, 8'd1));
    send_request(make_request(OP_HIGH, rand_num(), rand_num(), 8'h80));
    send_request(make_request(OP_SPARE, ones, ones, '1));
    send_request(make_request(OP_SPARE, rand_num(), rand_num(), '0));
    send_request(make_request(OP_MUL, {28'd0, 28'd0, 28'd1}, {28'd0, 28'd0, 28'd1}, '1));
    // The rounding constant alone sits just below the first kept bit; these
    // two land on either side of a carry into it.
    send_request(make_request(OP_MUL, {28'd1, 28'd0, 28'd0},
                              {28'd0, 28'd0, digit_t'(1) << ROUND_POS}, '0));
    send_request(make_request(OP_MUL, {28'd1, 28'd0, 28'd0},
                              {28'd0, 28'd0, digit_t'((1 << ROUND_POS) - 1)}, '0));
    send_request(make_request(OP_MUL, unit, rand_num(), '1));
    send_request(make_request(OP_SQUARE, unit, ones, '1));
    send_request(make_request(OP_SQUARE, rand_num(), ones, '1));
    send_request(make_request(OP_MUL, rand_num(), rand_num(), '1));
    send_request(make_request(OP_MUL, {DIGIT_MAX, 28'd0, 28'd0}, {DIGIT_MAX, 28'd0, 28'd0}, '0));
    send_request(make_request(OP_SQUARE, {28'd0, 28'd0, DIGIT_MAX}, zero, '0));
    send_request(make_request(OP_SQUARE, {28'd0, DIGIT_MAX, 28'd0}, ones, '0));
  endtask

  initial begin
    int unsigned gap_percent [3];
    gap_percent = '{35, 78, 0};
    start_i     <= 1'b0;
    operation_i <= OP_MUL;
    a_lo_i      <= '0;
    a_mid_i     <= '0;
    a_hi_i      <= '0;
    b_lo_i      <= '0;
    b_mid_i     <= '0;
    b_hi_i      <= '0;
    b_byte_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_idle(gap_percent[phase]);
        send_request(random_request());
      end
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tfpm_pkg.sv
hw/rtl/tfpm_operand.sv
hw/rtl/tfpm_mul_array.sv
hw/rtl/tfpm_carry.sv
hw/rtl/truncated_fixed_point_multiply.sv
bench/truncated_fixed_point_multiply_tb.sv
